// ===== rtl/sitda_pkg.sv =====
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal text core.
// ----------------------------------------------------------------------------
package sitda_pkg;

	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned MAX_DIGITS = 10;
	localparam int unsigned DIGIT_IDX_W = 4;

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;

	// floor(n / 10) == (n * RECIP_DIV10) >> DIV10_SHIFT for every 32-bit n
	localparam logic [VALUE_W-1:0] RECIP_DIV10 = 32'hCCCC_CCCD;
	localparam int unsigned        DIV10_SHIFT = 35;

	// One converted number: sign, index of the most significant digit and
	// the digits themselves, least significant at index 0.
	typedef struct packed {
		logic                                   neg;
		logic [DIGIT_IDX_W-1:0]                 msd;
		logic [MAX_DIGITS-1:0][3:0]             digits;
	} entry_t;

	typedef enum logic [1:0] {
		FRONT_IDLE,
		FRONT_CONV,
		FRONT_PUSH
	} front_state_t;

endpackage

// ===== rtl/sitda_front.sv =====
// ----------------------------------------------------------------------------
// sitda_front
// Takes a word, splits off the sign and peels decimal digits one per cycle
// with a reciprocal multiply, then hands the digit set to the queue.
// ----------------------------------------------------------------------------
module sitda_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [sitda_pkg::VALUE_W-1:0] value,
	output logic                                busy,
	output logic                                push,
	output sitda_pkg::entry_t                   push_entry,
	input  logic                                full
);

	sitda_pkg::front_state_t state_q, state_d;

	logic [sitda_pkg::VALUE_W-1:0]                 mag_q;
	logic                                          neg_q;
	logic [sitda_pkg::DIGIT_IDX_W-1:0]             cnt_q;
	logic [sitda_pkg::MAX_DIGITS-1:0][3:0]         dig_q;

	logic [sitda_pkg::VALUE_W-1:0]                 raw;
	logic                                          accept;
	logic [2*sitda_pkg::VALUE_W-1:0]               prod;
	logic [sitda_pkg::VALUE_W-1:0]                 quot;
	logic [3:0]                                    rem;
	logic                                          conv_done;

	assign raw    = value;
	assign accept = start && !busy;

	assign prod = {{sitda_pkg::VALUE_W{1'b0}}, mag_q} *
		{{sitda_pkg::VALUE_W{1'b0}}, sitda_pkg::RECIP_DIV10};
	assign quot = {{sitda_pkg::DIV10_SHIFT - sitda_pkg::VALUE_W{1'b0}},
		prod[2*sitda_pkg::VALUE_W-1:sitda_pkg::DIV10_SHIFT]};

	// remainder is below 10, so the low four bits of mag - 10*q are enough
	assign rem = mag_q[3:0] - {quot[2:0], 1'b0} - {quot[0], 3'b000};

	assign conv_done = (quot == '0) ||
		(cnt_q == sitda_pkg::DIGIT_IDX_W'(sitda_pkg::MAX_DIGITS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sitda_pkg::FRONT_IDLE: begin
				if (accept) state_d = sitda_pkg::FRONT_CONV;
			end
			sitda_pkg::FRONT_CONV: begin
				if (conv_done) state_d = sitda_pkg::FRONT_PUSH;
			end
			sitda_pkg::FRONT_PUSH: begin
				if (!full) state_d = accept ? sitda_pkg::FRONT_CONV : sitda_pkg::FRONT_IDLE;
			end
			default: state_d = sitda_pkg::FRONT_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b1;
		push = 1'b0;
		unique case (state_q)
			sitda_pkg::FRONT_IDLE: busy = 1'b0;
			sitda_pkg::FRONT_CONV: busy = 1'b1;
			sitda_pkg::FRONT_PUSH: begin
				busy = full;
				push = !full;
			end
			default: busy = 1'b1;
		endcase
	end

	assign push_entry.neg    = neg_q;
	assign push_entry.msd    = cnt_q;
	assign push_entry.digits = dig_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sitda_pkg::FRONT_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= raw[sitda_pkg::VALUE_W-1];
			mag_q <= raw[sitda_pkg::VALUE_W-1] ? ({sitda_pkg::VALUE_W{1'b0}} - raw) : raw;
			cnt_q <= '0;
		end else if (state_q == sitda_pkg::FRONT_CONV) begin
			dig_q[cnt_q] <= rem;
			mag_q        <= quot;
			if (!conv_done) cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

// ===== rtl/sitda_queue.sv =====
// ----------------------------------------------------------------------------
// sitda_queue
// Small register queue of converted numbers between front and back.
// ----------------------------------------------------------------------------
module sitda_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sitda_pkg::entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output sitda_pkg::entry_t head,
	output logic              empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	sitda_pkg::entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

// ===== rtl/sitda_back.sv =====
// ----------------------------------------------------------------------------
// sitda_back
// Pulls converted numbers from the queue and sends the text out one
// character per cycle: optional minus, then digits most significant first.
// ----------------------------------------------------------------------------
module sitda_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sitda_pkg::entry_t head,
	input  logic              empty,
	output logic              pop,
	output logic              strobe,
	output logic [7:0]        char_code,
	output logic              is_last
);

	logic                                   active_q;
	logic                                   sign_q;
	logic [sitda_pkg::DIGIT_IDX_W-1:0]      pos_q;
	logic [sitda_pkg::MAX_DIGITS-1:0][3:0]  dig_q;
	logic                                   strobe_q;
	logic [7:0]                             char_q;
	logic                                   last_q;

	logic finishing;
	logic at_last;

	assign at_last   = !sign_q && (pos_q == '0);
	assign finishing = active_q && at_last;
	// next word loads in the cycle the last character is registered: no gap
	assign pop       = !empty && (!active_q || finishing);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (pop)            active_q <= 1'b1;
			else if (finishing) active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sign_q <= head.neg;
			pos_q  <= head.msd;
			dig_q  <= head.digits;
		end else if (active_q) begin
			if (sign_q) sign_q <= 1'b0;
			else        pos_q  <= pos_q - 1'b1;
		end
		char_q <= sign_q ? sitda_pkg::ASCII_MINUS : (sitda_pkg::ASCII_ZERO + {4'd0, dig_q[pos_q]});
		last_q <= at_last;
	end

	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign is_last   = last_q;

endmodule

// ===== rtl/signed_int_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a signed 32-bit integer into its decimal ASCII text.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Its text leaves as
// 1 to 11 characters, one per cycle, each marked by strobe for a single
// cycle, with is_last on the final one; there is no backpressure, so the
// receiver must take every character as it comes. The front peels one
// digit per cycle with a divide-by-ten multiply, and it can take a new
// word as it pushes the last one into the queue, unless the queue is full;
// the output side sends one character per cycle while the queue holds
// words, with no gap between texts. A short queue lets the front convert
// the next word while the current text is still going out.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [sitda_pkg::VALUE_W-1:0] value,
	output logic                                 strobe,
	output logic [7:0]                           char_code,
	output logic                                 is_last
);

	logic              push;
	sitda_pkg::entry_t push_entry;
	logic              full;
	logic              pop;
	sitda_pkg::entry_t head;
	logic              empty;

	sitda_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.value      (value),
		.busy       (busy),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	sitda_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.empty      (empty)
	);

	sitda_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.strobe    (strobe),
		.char_code (char_code),
		.is_last   (is_last)
	);

endmodule

// ===== tb/signed_int_to_decimal_ascii_core_test.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core_test
// Self-checking bench for the signed integer to decimal text core.
// ----------------------------------------------------------------------------
// Each word sent is turned into its expected characters by a local
// predictor, and every strobed character is compared in order against
// them. Stimulus covers the extremes, every text length and both signs,
// then random words with random sender gaps and back-to-back bursts.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IDLE_LIMIT    = 1000;
	localparam int unsigned MAX_REPORTS   = 10;
	localparam int unsigned RANDOM_WORDS  = 320;
	localparam int unsigned SETTLE_CYCLES = 30;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	logic                                  clk;
	logic                                  arst_n;
	logic                                  start;
	logic                                  busy;
	logic signed [sitda_pkg::VALUE_W-1:0]  value;
	logic                                  strobe;
	logic [7:0]                            char_code;
	logic                                  is_last;

	text_char_t  pending_chars[$];
	int unsigned mismatch_count = 0;
	int unsigned idle_cycles = 0;

	signed_int_to_decimal_ascii_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.strobe    (strobe),
		.char_code (char_code),
		.is_last   (is_last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Expected text of one word: optional minus, then digits, msd first
	task automatic queue_decimal_text(input logic [sitda_pkg::VALUE_W-1:0] word);
		logic                            neg;
		logic [sitda_pkg::VALUE_W-1:0]   mag;
		logic [3:0]                      digs [sitda_pkg::MAX_DIGITS];
		int                              n;
		text_char_t                      ch;
		neg = word[sitda_pkg::VALUE_W-1];
		mag = neg ? (32'd0 - word) : word;
		n = 0;
		do begin
			digs[n] = 4'(mag % 10);
			mag = mag / 10;
			n++;
		end while (mag != 0 && n < sitda_pkg::MAX_DIGITS);
		if (neg) begin
			ch.code = sitda_pkg::ASCII_MINUS;
			ch.last = 1'b0;
			pending_chars.push_back(ch);
		end
		for (int i = n - 1; i >= 0; i--) begin
			ch.code = sitda_pkg::ASCII_ZERO + 8'(digs[i]);
			ch.last = (i == 0);
			pending_chars.push_back(ch);
		end
	endtask

	// Prediction on accepted words, character checks, idle count
	always @(posedge clk) begin
		text_char_t exp_ch;
		if (arst_n) begin
			if (start && !busy)
				queue_decimal_text(value);
			if (strobe) begin
				if (pending_chars.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: unexpected char 0x%02h last=%b", $realtime,
							char_code, is_last);
				end else begin
					exp_ch = pending_chars.pop_front();
					if (char_code !== exp_ch.code || is_last !== exp_ch.last) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("%0t: char mismatch exp 0x%02h last=%b, got 0x%02h last=%b",
								$realtime, exp_ch.code, exp_ch.last, char_code, is_last);
					end
				end
			end
			if ((start && !busy) || strobe)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	// Hold start after each word; a gap of zero keeps it high for the next one
	task automatic send_word(input logic [sitda_pkg::VALUE_W-1:0] word,
		input int unsigned gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		value <= word;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending_chars.size() != 0);
	endtask

	task automatic test_directed();
		logic [sitda_pkg::VALUE_W-1:0] words[$];
		words = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
			32'd7, -32'sd5, 32'd2147483647, 32'h8000_0000, 32'h8000_0001,
			32'd1000000000, 32'd999999999, -32'sd999999999, -32'sd1000000000,
			32'd1000000001, 32'd123456789, -32'sd12345, 32'h5555_5555, 32'hAAAA_AAAA};
		foreach (words[i])
			send_word(words[i], $urandom_range(19, 0));
	endtask

	// Back-to-back burst, then the sender holds off until the text is all out
	task automatic test_drain_pause();
		for (int i = 0; i < 6; i++)
			send_word($urandom, 0);
		wait_drained();
		send_word(32'h8000_0000, 0);
		send_word(32'd0, 0);
		wait_drained();
	endtask

	function automatic logic [sitda_pkg::VALUE_W-1:0] pick_random_word();
		longint lo;
		longint hi;
		longint mag;
		int     ndig;
		int     kind;
		kind = $urandom_range(99, 0);
		if (kind < 50) begin
			// uniform over digit count, random sign
			ndig = $urandom_range(sitda_pkg::MAX_DIGITS, 1);
			lo = (ndig == 1) ? 0 : 1;
			for (int i = 1; i < ndig; i++)
				lo = lo * 10;
			hi = (ndig == 1) ? 9 : lo * 10 - 1;
			if (hi > 64'd2147483647)
				hi = 64'd2147483647;
			mag = $urandom_range(int'(hi), int'(lo));
			return $urandom_range(1, 0) ? sitda_pkg::VALUE_W'(-mag)
				: sitda_pkg::VALUE_W'(mag);
		end else if (kind < 75) begin
			return $urandom;
		end else if (kind < 90) begin
			return sitda_pkg::VALUE_W'(longint'($urandom_range(40, 0)) - 20);
		end else begin
			// close to the ends of the range
			mag = $urandom_range(3, 0);
			return $urandom_range(1, 0) ? sitda_pkg::VALUE_W'(32'h8000_0000 + mag)
				: sitda_pkg::VALUE_W'(32'h7FFF_FFFF - mag);
		end
	endfunction

	task automatic test_random_words();
		bit burst;
		burst = 1'b0;
		for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 25 == 0)
				burst = ($urandom_range(2, 0) == 0);
			send_word(pick_random_word(), burst ? 0 : $urandom_range(19, 0));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		value  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_drain_pause();
		test_random_words();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
